@@ sv/uyvy_pkg.sv @@
// Package: beat types, chroma terms and BT.601 integer constants for the UYVY converter.
package uyvy_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SumW  = 20;  // holds every weighted sum, incl. rounding bias

  localparam logic signed [SumW-1:0] YWeight    = 20'sd298;
  localparam logic signed [SumW-1:0] RFromCr    = 20'sd409;
  localparam logic signed [SumW-1:0] GFromCb    = 20'sd100;
  localparam logic signed [SumW-1:0] GFromCr    = 20'sd208;
  localparam logic signed [SumW-1:0] BFromCb    = 20'sd516;
  localparam logic signed [SumW-1:0] RoundBias  = 20'sd128;
  localparam logic signed [SumW-1:0] LumaOffset = 20'sd16;
  localparam int unsigned FracBits = 8;
  localparam logic [ByteW-1:0] ChanMax = 8'd255;

  typedef struct packed {
    logic [ByteW-1:0] cb_byte;
    logic [ByteW-1:0] luma_first;
    logic [ByteW-1:0] cr_byte;
    logic [ByteW-1:0] luma_second;
  } uyvy_in_t;

  typedef struct packed {
    logic [ByteW-1:0] red_first;
    logic [ByteW-1:0] green_first;
    logic [ByteW-1:0] blue_first;
    logic [ByteW-1:0] red_second;
    logic [ByteW-1:0] green_second;
    logic [ByteW-1:0] blue_second;
    logic [ByteW-1:0] alpha_value;
  } rgba_out_t;

  // Chroma contributions shared by both lanes, bias already folded in
  typedef struct packed {
    logic signed [SumW-1:0] red_term;
    logic signed [SumW-1:0] green_term;
    logic signed [SumW-1:0] blue_term;
  } chroma_t;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
  } rgb_t;

endpackage

@@ sv/uyvy_chroma.sv @@
// Shared chroma stage: registers the Cb/Cr weighted terms used by both pixel lanes.
module uyvy_chroma (
  input  logic                    clk,
  input  logic                    load,
  input  logic [7:0]              cb_byte,
  input  logic [7:0]              cr_byte,
  output uyvy_pkg::chroma_t       chroma
);
  import uyvy_pkg::*;

  logic signed [SumW-1:0] d_ext;
  logic signed [SumW-1:0] e_ext;
  chroma_t chroma_nxt;
  chroma_t chroma_r;

  // subtracting 128 from a byte is just flipping its top bit
  assign d_ext = SumW'($signed({~cb_byte[7], cb_byte[6:0]}));
  assign e_ext = SumW'($signed({~cr_byte[7], cr_byte[6:0]}));

  always_comb begin
    chroma_nxt.red_term   = RFromCr * e_ext + RoundBias;
    chroma_nxt.green_term = RoundBias - GFromCb * d_ext - GFromCr * e_ext;
    chroma_nxt.blue_term  = BFromCb * d_ext + RoundBias;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chroma_r <= chroma_nxt;
    end
  end

  assign chroma = chroma_r;

endmodule

@@ sv/uyvy_lane.sv @@
// One pixel lane: registered luma product, then add chroma terms, shift and clamp.
module uyvy_lane (
  input  logic                    clk,
  input  logic                    load,
  input  logic [7:0]              luma,
  input  uyvy_pkg::chroma_t       chroma,
  output uyvy_pkg::rgb_t          pixel
);
  import uyvy_pkg::*;

  logic signed [SumW-1:0] c_ext;
  logic signed [SumW-1:0] yc_nxt;
  logic signed [SumW-1:0] yc_r;

  function automatic logic [ByteW-1:0] clamp_chan(input logic signed [SumW-1:0] sum);
    logic [SumW-1:0] shifted;
    shifted = $unsigned(sum) >> FracBits;
    if (sum[SumW-1]) begin
      clamp_chan = '0;
    end else if (|shifted[SumW-1:ByteW]) begin
      clamp_chan = ChanMax;
    end else begin
      clamp_chan = shifted[ByteW-1:0];
    end
  endfunction

  assign c_ext  = $signed({{(SumW-ByteW){1'b0}}, luma}) - LumaOffset;
  assign yc_nxt = YWeight * c_ext;

  always_ff @(posedge clk) begin
    if (load) begin
      yc_r <= yc_nxt;
    end
  end

  always_comb begin
    pixel.red   = clamp_chan(yc_r + chroma.red_term);
    pixel.green = clamp_chan(yc_r + chroma.green_term);
    pixel.blue  = clamp_chan(yc_r + chroma.blue_term);
  end

endmodule

@@ sv/uyvy_to_rgba_converter.sv @@
// Top level: UYVY macropixel to two RGBA pixels, two lanes plus merging output register.
// One UYVY macropixel is taken per clock while in_stall is low; its two pixels leave
// together via a product stage (luma products in each of the two pixel lanes, chroma
// terms computed once and shared) then the output register, where the lanes' clamped
// channels and the constant alpha of 255 are merged into one beat. With out_stall low
// the block sustains one beat per cycle; while a result waits at the output, one more
// beat is still taken into the product stage before in_stall rises.
module uyvy_to_rgba_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  uyvy_pkg::uyvy_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output uyvy_pkg::rgba_out_t   out_data
);
  import uyvy_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      s1_load, s2_load, in_accept;
  chroma_t   chroma;
  rgb_t      pix_first, pix_second;
  rgba_out_t out_r, out_nxt;

  assign s2_load   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s2_load;
  assign in_accept = in_valid && !in_stall;
  assign s1_load   = in_accept;

  uyvy_chroma u_chroma (
    .clk     (clk),
    .load    (s1_load),
    .cb_byte (in_data.cb_byte),
    .cr_byte (in_data.cr_byte),
    .chroma  (chroma)
  );

  uyvy_lane u_lane_first (
    .clk    (clk),
    .load   (s1_load),
    .luma   (in_data.luma_first),
    .chroma (chroma),
    .pixel  (pix_first)
  );

  uyvy_lane u_lane_second (
    .clk    (clk),
    .load   (s1_load),
    .luma   (in_data.luma_second),
    .chroma (chroma),
    .pixel  (pix_second)
  );

  always_comb begin
    out_nxt.red_first    = pix_first.red;
    out_nxt.green_first  = pix_first.green;
    out_nxt.blue_first   = pix_first.blue;
    out_nxt.red_second   = pix_second.red;
    out_nxt.green_second = pix_second.green;
    out_nxt.blue_second  = pix_second.blue;
    out_nxt.alpha_value  = ChanMax;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s2_load) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload follows the valid bit; stage one only moves on when it holds a beat
  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a beat parked in stage one must not vanish while the output is blocked
  a_s1_held : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r)
    else $error("stage one beat dropped while output stalled");

  a_s1_moves : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_load |=> out_valid_r)
    else $error("stage one beat not moved to output");

  a_no_accept_full : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |-> in_stall)
    else $error("beat accepted with both stages full and blocked");

  a_alpha : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.alpha_value == ChanMax)
    else $error("alpha not opaque");

endmodule

@@ tb/uyvy_to_rgba_checker.sv @@
// Checker: watches both channels, predicts each RGBA beat from its UYVY beat and compares.
module uyvy_to_rgba_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  uyvy_pkg::uyvy_in_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  uyvy_pkg::rgba_out_t  out_data,
  output int                   fail_count,
  output int                   beats_outstanding
);
  import uyvy_pkg::*;

  localparam int LumaBias   = 16;
  localparam int ChromaBias = 128;
  localparam int WeightY    = 298;
  localparam int WeightRCr  = 409;
  localparam int WeightGCb  = 100;
  localparam int WeightGCr  = 208;
  localparam int WeightBCb  = 516;
  localparam int HalfLsb    = 128;
  localparam int ByteMax    = 255;
  localparam int MaxReports = 10;

  rgba_out_t expected_pixels[$];
  int        beat_index;

  // floor shift; anything negative becomes black, anything past full scale saturates
  function automatic logic [7:0] clamp_to_byte(int sum);
    int shifted;
    if (sum < 0) return 8'd0;
    shifted = sum >>> 8;
    if (shifted > ByteMax) return 8'd255;
    return shifted[7:0];
  endfunction

  function automatic rgb_t lane_rgb(int luma, int d, int e);
    rgb_t px;
    int   yc;
    yc       = WeightY * (luma - LumaBias);
    px.red   = clamp_to_byte(yc + WeightRCr * e + HalfLsb);
    px.green = clamp_to_byte(yc - WeightGCb * d - WeightGCr * e + HalfLsb);
    px.blue  = clamp_to_byte(yc + WeightBCb * d + HalfLsb);
    return px;
  endfunction

  function automatic rgba_out_t predict_rgba(uyvy_in_t mp);
    rgba_out_t res;
    rgb_t      p0;
    rgb_t      p1;
    int        d;
    int        e;
    d  = int'(mp.cb_byte) - ChromaBias;
    e  = int'(mp.cr_byte) - ChromaBias;
    p0 = lane_rgb(int'(mp.luma_first), d, e);
    p1 = lane_rgb(int'(mp.luma_second), d, e);
    res.red_first    = p0.red;
    res.green_first  = p0.green;
    res.blue_first   = p0.blue;
    res.red_second   = p1.red;
    res.green_second = p1.green;
    res.blue_second  = p1.blue;
    res.alpha_value  = 8'd255;
    return res;
  endfunction

  always @(posedge clk) begin
    rgba_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_pixels.push_back(predict_rgba(in_data));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("unexpected output beat %0d: got %h", beat_index, out_data);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.red_first    !== want.red_first    ||
              out_data.green_first  !== want.green_first  ||
              out_data.blue_first   !== want.blue_first   ||
              out_data.red_second   !== want.red_second   ||
              out_data.green_second !== want.green_second ||
              out_data.blue_second  !== want.blue_second  ||
              out_data.alpha_value  !== want.alpha_value) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display("mismatch beat %0d: exp rgb0 %0d %0d %0d rgb1 %0d %0d %0d a %0d",
                       beat_index, want.red_first, want.green_first, want.blue_first,
                       want.red_second, want.green_second, want.blue_second,
                       want.alpha_value, "\n                  got rgb0 %0d %0d %0d",
                       out_data.red_first, out_data.green_first, out_data.blue_first,
                       " rgb1 %0d %0d %0d a %0d", out_data.red_second,
                       out_data.green_second, out_data.blue_second, out_data.alpha_value);
          end
        end
        beat_index++;
      end
      beats_outstanding = expected_pixels.size();
    end
  end

endmodule

@@ tb/uyvy_to_rgba_converter_tb.sv @@
// Testbench top: drives UYVY beats with random idling and back-pressure, gives the verdict.
module uyvy_to_rgba_converter_tb;
  import uyvy_pkg::*;

  localparam int BeatsPerPhase = 200;
  localparam int LongHoldCycles = 80;
  localparam int DrainCycles = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  uyvy_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  rgba_out_t out_data;

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  bit start_long_hold = 1'b0;
  int fail_count;
  int beats_outstanding;

  always #5 clk = ~clk;

  uyvy_to_rgba_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  uyvy_to_rgba_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data),
    .fail_count        (fail_count),
    .beats_outstanding (beats_outstanding)
  );

  // values around the offsets and clamp edges turn up more often than by chance
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[13] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128,
                              8'd129, 8'd234, 8'd235, 8'd240, 8'd254, 8'd255};
    if ($urandom_range(99) < 25) return edges[$urandom_range(12)];
    return 8'($urandom_range(255));
  endfunction

  function automatic uyvy_in_t random_macropixel();
    uyvy_in_t mp;
    mp.cb_byte     = pick_byte();
    mp.luma_first  = pick_byte();
    mp.cr_byte     = pick_byte();
    mp.luma_second = pick_byte();
    return mp;
  endfunction

  task automatic send_beat(input uyvy_in_t mp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= mp;
    do @(posedge clk); while (in_stall);
  endtask

  // receiver: random stalls, plus one long hold-off so the pipe fills and backs up
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (start_long_hold && !hold_done) begin
        hold_left = LongHoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 59;
    // corners: black, white, saturated luma, chroma extremes, bit patterns
    send_beat({8'd0,   8'd0,   8'd0,   8'd0});
    send_beat({8'd255, 8'd255, 8'd255, 8'd255});
    send_beat({8'd128, 8'd16,  8'd128, 8'd16});
    send_beat({8'd128, 8'd235, 8'd128, 8'd235});
    send_beat({8'd128, 8'd255, 8'd128, 8'd0});
    send_beat({8'd128, 8'd0,   8'd128, 8'd255});
    send_beat({8'd0,   8'd128, 8'd0,   8'd128});
    send_beat({8'd255, 8'd128, 8'd255, 8'd128});
    send_beat({8'd0,   8'd128, 8'd255, 8'd128});
    send_beat({8'd255, 8'd128, 8'd0,   8'd128});
    send_beat({8'd0,   8'd255, 8'd255, 8'd0});
    send_beat({8'd255, 8'd0,   8'd0,   8'd255});
    send_beat({8'd240, 8'd235, 8'd16,  8'd16});
    send_beat({8'd16,  8'd16,  8'd240, 8'd235});
    send_beat({8'd129, 8'd17,  8'd127, 8'd15});
    send_beat({8'h55,  8'hAA,  8'h55,  8'hAA});
    send_beat({8'hAA,  8'h55,  8'hAA,  8'h55});
    send_beat({8'h01,  8'h80,  8'h01,  8'h80});
    send_beat({8'h80,  8'h01,  8'h80,  8'h01});
    send_beat({8'd90,  8'd81,  8'd240, 8'd145});
    repeat (BeatsPerPhase) send_beat(random_macropixel());

    send_idle_pct = 59;
    recv_idle_pct = 10;
    repeat (BeatsPerPhase) send_beat(random_macropixel());

    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    start_long_hold = 1'b1;
    repeat (BeatsPerPhase) send_beat(random_macropixel());
    in_valid <= 1'b0;

    @(negedge clk);
    while (beats_outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && beats_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ files.f @@
sv/uyvy_pkg.sv
sv/uyvy_chroma.sv
sv/uyvy_lane.sv
sv/uyvy_to_rgba_converter.sv
tb/uyvy_to_rgba_checker.sv
tb/uyvy_to_rgba_converter_tb.sv
